// File: hw/rtl/flory_huggins_chempot_update_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef FLORY_HUGGINS_CHEMPOT_UPDATE_MACROS_SVH
`define FLORY_HUGGINS_CHEMPOT_UPDATE_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define FHCU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define FHCU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fhcu_pkg.sv
// ----------------------------------------------------------------------------
// fhcu_pkg
// Types and fixed-point constants of the Flory-Huggins potential update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhcu_pkg;

  // Q2.30 one and ln(2) in Q.28
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  // Register reset values (1.0 in Q8.24)
  localparam logic [31:0] SCALE_RESET = 32'h0100_0000;
  localparam logic [31:0] CHI_RESET   = 32'h0100_0000;

  // Width of a log2 value in Q.30, range [-30, 0]
  localparam int LOG_W = 37;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCALE = 2'd0,
    CFG_CHI   = 2'd1
  } cfg_idx_t;

  // Per-point fields that travel beside the arithmetic
  typedef struct packed {
    logic [29:0]        phi;
    logic signed [31:0] mu;
    logic               was_low;
    logic               was_high;
    logic [31:0]        low_count;
    logic [31:0]        high_count;
  } side_t;

endpackage

`default_nettype wire

// File: hw/rtl/fhcu_mirror.sv
// ----------------------------------------------------------------------------
// fhcu_mirror
// Mirrors phi at 0 and 1, clamps it into (0,1), counts mirrors and forms 1-phi, 1-2phi.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhcu_mirror (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               accept,
  input  wire logic signed [31:0] phi_in,
  input  wire logic signed [31:0] mu_in,
  output fhcu_pkg::side_t         side,
  output logic [29:0]             q,
  output logic signed [30:0]      lin
);

  logic signed [33:0] phi_x;
  logic signed [33:0] phi_m;
  logic signed [33:0] phi_c;
  logic               low_c;
  logic               high_c;
  logic [29:0]        p;
  logic [31:0]        low_mirror_count;
  logic [31:0]        high_mirror_count;
  logic [31:0]        low_mirror_count_next;
  logic [31:0]        high_mirror_count_next;
  logic signed [31:0] lin_w;

  // Mirror and clamp
  always_comb begin
    phi_x  = {{2{phi_in[31]}}, phi_in};
    low_c  = (phi_x <= 34'sd0);
    high_c = !low_c && (phi_x >= $signed({2'b00, fhcu_pkg::ONE_Q30}));
    if (low_c) begin
      phi_m = -phi_x;
    end else if (high_c) begin
      phi_m = $signed({1'b0, fhcu_pkg::ONE_Q30, 1'b0}) - phi_x;
    end else begin
      phi_m = phi_x;
    end
    if (phi_m < 34'sd1) begin
      phi_c = 34'sd1;
    end else if (phi_m > 34'sd1073741823) begin
      phi_c = 34'sd1073741823;
    end else begin
      phi_c = phi_m;
    end
    p = phi_c[29:0];
    lin_w = $signed(fhcu_pkg::ONE_Q30) - $signed({1'b0, p, 1'b0});
    low_mirror_count_next  = low_mirror_count + {31'd0, low_c};
    high_mirror_count_next = high_mirror_count + {31'd0, high_c};
  end

  // Advance the wrapping mirror counters per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      low_mirror_count  <= '0;
      high_mirror_count <= '0;
    end else if (accept) begin
      low_mirror_count  <= low_mirror_count_next;
      high_mirror_count <= high_mirror_count_next;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (en) begin
      side.phi        <= p;
      side.mu         <= mu_in;
      side.was_low    <= low_c;
      side.was_high   <= high_c;
      side.low_count  <= low_mirror_count_next;
      side.high_count <= high_mirror_count_next;
      q               <= 30'(31'h4000_0000 - {1'b0, p});
      lin             <= lin_w[30:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fhcu_log2.sv
// ----------------------------------------------------------------------------
// fhcu_log2
// Five-stage log2 of a Q0.30 value: normalize, index, table, interpolate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhcu_log2 #(
  parameter int LOG_TABLE_DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [29:0]                         p,
  output logic signed [fhcu_pkg::LOG_W-1:0]        logv
);

  localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
  localparam int DW    = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int SW    = 30 + DW;

  typedef logic [61:0] rom_t [LOG_TABLE_DEPTH];

  // log2(1 + i/depth) in Q.30 by repeated squaring
  function automatic logic [30:0] log_entry(input int unsigned i);
    logic [63:0] m;
    logic [30:0] y;
    m = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
    y = '0;
    for (int k = 1; k <= 30; k++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        y[30-k] = 1'b1;
      end
    end
    if (i >= LOG_TABLE_DEPTH) begin
      y = 31'h4000_0000;
    end
    return y;
  endfunction

  // Each row holds an entry and its upper neighbor
  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      r[i] = {log_entry(i + 1), log_entry(i)};
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  logic [4:0]       msb;
  logic [30:0]      norm;
  logic [4:0]       b1, b2, b3, b4;
  logic [29:0]      f1;
  logic [SW-1:0]    scaled;
  logic [IDX_W-1:0] idx2;
  logic [29:0]      rem2, rem3;
  logic [61:0]      pair3;
  logic [30:0]      lo, hi;
  logic [30:0]      lo4;
  logic [60:0]      iprod4;
  logic [31:0]      frac;
  logic [36:0]      offs;

  // Find the leading one and normalize
  always_comb begin
    msb = '0;
    for (int j = 0; j < 30; j++) begin
      if (p[j]) begin
        msb = 5'(j);
      end
    end
    norm = {1'b0, p} << (5'd30 - msb);
  end

  // Table address and remainder, row split, fraction sum and exponent offset
  always_comb begin
    scaled = SW'(f1) * SW'(LOG_TABLE_DEPTH);
    lo     = pair3[30:0];
    hi     = pair3[61:31];
    frac   = {1'b0, lo4} + {1'b0, iprod4[60:30]};
    offs   = {2'b00, 5'(5'd30 - b4), 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // normalize
      b1     <= msb;
      f1     <= norm[29:0];
      // index
      b2     <= b1;
      idx2   <= scaled[30+IDX_W-1:30];
      rem2   <= scaled[29:0];
      // table read
      b3     <= b2;
      rem3   <= rem2;
      pair3  <= LOG_ROM[idx2];
      // interpolation product
      b4     <= b3;
      lo4    <= lo;
      iprod4 <= (hi - lo) * rem3;
      // exponent and fraction
      logv   <= $signed({5'd0, frac}) - $signed(offs);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fhcu_chem.sv
// ----------------------------------------------------------------------------
// fhcu_chem
// Chi term, ln ratio, scaling and saturating add to the chemical potential.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhcu_chem (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [31:0]                        scale,
  input  wire logic signed [31:0]                 chi_coeff,
  input  wire logic signed [30:0]                 lin,
  input  wire logic signed [fhcu_pkg::LOG_W-1:0]  logp,
  input  wire logic signed [fhcu_pkg::LOG_W-1:0]  logq,
  input  wire logic signed [31:0]                 mu,
  output logic signed [31:0]                      mu_out
);

  logic signed [62:0] cprod;
  logic [62:0]        cmag;
  logic [38:0]        cshift;
  logic signed [38:0] chiterm;
  logic signed [38:0] chi_dly [6];
  logic signed [37:0] diff;
  logic signed [65:0] lprod;
  logic [65:0]        lmag;
  logic [37:0]        lshift;
  logic signed [38:0] lnratio;
  logic signed [38:0] sum;
  logic [38:0]        mag;
  logic               neg8, neg9;
  logic [38:0]        mag8;
  logic [54:0]        pa9, pb9;
  logic [55:0]        tsum;
  logic [33:0]        dmag;
  logic signed [35:0] delta;
  logic signed [35:0] res;

  // Truncate products toward zero, then add them and take the magnitude
  always_comb begin
    cmag    = cprod[62] ? 63'(-cprod) : 63'(cprod);
    cshift  = 39'(cmag >> 24);
    chiterm = cprod[62] ? -$signed(cshift) : $signed(cshift);
    lmag    = lprod[65] ? 66'(-lprod) : 66'(lprod);
    lshift  = 38'(lmag >> 28);
    lnratio = lprod[65] ? -$signed({1'b0, lshift}) : $signed({1'b0, lshift});
    sum     = lnratio + chi_dly[5];
    mag     = sum[38] ? 39'(-sum) : 39'(sum);
  end

  // Scale, then add to mu; the saturation is registered below
  always_comb begin
    tsum  = {1'b0, pa9} + {17'd0, pb9[54:16]};
    dmag  = tsum[55:22];
    delta = neg9 ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
    res   = $signed({{4{mu[31]}}, mu}) + delta;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // chi product and its truncation, then align with the log path
      cprod      <= chi_coeff * lin;
      chi_dly[0] <= chiterm;
      for (int k = 1; k < 6; k++) begin
        chi_dly[k] <= chi_dly[k-1];
      end
      // log ratio times ln 2
      diff  <= {logp[fhcu_pkg::LOG_W-1], logp} - {logq[fhcu_pkg::LOG_W-1], logq};
      lprod <= diff * $signed({1'b0, fhcu_pkg::LN2_Q28});
      // sum magnitude
      neg8  <= sum[38];
      mag8  <= mag;
      // partial products with scale
      neg9  <= neg8;
      pa9   <= mag8 * scale[31:16];
      pb9   <= mag8 * scale[15:0];
      // saturate to Q16.16
      if (res > 36'sd2147483647) begin
        mu_out <= 32'sh7FFF_FFFF;
      end else if (res < -36'sd2147483648) begin
        mu_out <= 32'sh8000_0000;
      end else begin
        mu_out <= res[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/flory_huggins_chempot_update.sv
// ----------------------------------------------------------------------------
// flory_huggins_chempot_update
// Per grid point mirror of phi and Flory-Huggins chemical potential update.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | phi_in[31:0], mu_in[63:32]                  | -
//  m_*     | out | phi_out, mu_out, low_count, high_count, pad | was_low, was_high
//  cfg_*   | in  | index 0 scale, index 1 chi_coeff            | -
//
//  One point per cycle while the output is not stalled; each point passes the
//  mirror register, the log2 table pipeline and the scale multipliers.
//  Reset clears the registers to 1.0, the counters and all valid bits.
//  A stall at the output freezes the whole pipeline and drops s_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flory_huggins_chempot_update #(
  parameter int LOG_TABLE_DEPTH = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // phi_in, mu_in
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // phi_out, mu_out, low_count, high_count, zero pad
  output logic [1:0]        m_tuser,   // was_low, was_high
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int NSTG = 11;

  logic                                  en;
  logic                                  accept;
  logic [NSTG-1:0]                       v;
  fhcu_pkg::side_t                       side0;
  fhcu_pkg::side_t                       side [1:NSTG-1];
  logic [29:0]                           q0;
  logic signed [30:0]                    lin0;
  logic signed [fhcu_pkg::LOG_W-1:0]     logp;
  logic signed [fhcu_pkg::LOG_W-1:0]     logq;
  logic signed [31:0]                    mu_res;
  logic [31:0]                           scale;
  logic signed [31:0]                    chi_coeff;

  // Advance whenever the output slot is free or taken
  assign en       = !v[NSTG-1] || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= fhcu_pkg::SCALE_RESET;
      chi_coeff <= fhcu_pkg::CHI_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        fhcu_pkg::CFG_SCALE: scale     <= cfg_wdata;
        fhcu_pkg::CFG_CHI:   chi_coeff <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-2:0], accept};
    end
  end

  // Side fields ride with the valid bits
  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side0;
      for (int k = 2; k < NSTG; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  fhcu_mirror u_mirror (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .accept (accept),
    .phi_in (s_tdata[31:0]),
    .mu_in  (s_tdata[63:32]),
    .side   (side0),
    .q      (q0),
    .lin    (lin0)
  );

  fhcu_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_p (
    .clk  (clk),
    .en   (en),
    .p    (side0.phi),
    .logv (logp)
  );

  fhcu_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_q (
    .clk  (clk),
    .en   (en),
    .p    (q0),
    .logv (logq)
  );

  fhcu_chem u_chem (
    .clk       (clk),
    .en        (en),
    .scale     (scale),
    .chi_coeff (chi_coeff),
    .lin       (lin0),
    .logp      (logp),
    .logq      (logq),
    .mu        (side[NSTG-2].mu),
    .mu_out    (mu_res)
  );

  // Output transaction
  assign m_tvalid = v[NSTG-1];
  assign m_tdata  = {2'b00, side[NSTG-1].high_count, side[NSTG-1].low_count,
                     mu_res, side[NSTG-1].phi};
  assign m_tuser  = {side[NSTG-1].was_high, side[NSTG-1].was_low};

endmodule

`default_nettype wire

// File: hw/rtl/fhcu_checker.sv
// ----------------------------------------------------------------------------
// fhcu_checker
// Port-level checks of the chemical potential update, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "flory_huggins_chempot_update_macros.svh"

module fhcu_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata,
  input wire logic [1:0]   m_tuser
);

  // Hold a stalled result
  `FHCU_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  // Take input whenever the output slot is empty
  `FHCU_ASSERT(a_ready, clk, rst, !m_tvalid |-> s_tready, "input blocked with empty output")
  // One mirror per point at most, and phi never zero
  `FHCU_ASSERT(a_flags, clk, rst, m_tvalid |-> !(m_tuser[0] && m_tuser[1]) && (m_tdata[29:0] != 30'd0), "bad mirror flags or phi")
  // Reset empties the pipeline
  `FHCU_ASSERT_ALWAYS(a_reset, clk, rst |=> !m_tvalid, "result after reset")

endmodule

bind flory_huggins_chempot_update fhcu_checker u_checker (.*);

`default_nettype wire

// File: dv/tb_flory_huggins_chempot_update.sv
// ----------------------------------------------------------------------------
// tb_flory_huggins_chempot_update
// Self-checking bench for the Flory-Huggins chemical potential update.
// Sends directed and random grid points through the input stream. Predicts
// each result with a fixed-point log2 table model and compares it field by
// field at the output. Steps through several register settings and idle
// patterns, with one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_flory_huggins_chempot_update;

  localparam int TBL_DEPTH = 1024;
  localparam int PIPE_LAT  = 11;
  localparam int N_PHASES  = 8;
  localparam int PHASE_PTS = 229;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint LN2 = 64'sd186065279;

  typedef struct packed {
    logic [29:0]        phi;
    logic signed [31:0] mu;
    logic               was_low;
    logic               was_high;
    logic [31:0]        low_count;
    logic [31:0]        high_count;
  } point_res_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;   // phi_in, mu_in
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // phi_out, mu_out, low_count, high_count, zero pad
  logic [1:0]   m_tuser;   // was_low, was_high
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  flory_huggins_chempot_update #(.LOG_TABLE_DEPTH(TBL_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  longint unsigned log2_tbl[TBL_DEPTH+1];
  logic [31:0]        scale_reg;
  logic signed [31:0] chi_reg;
  logic [31:0]        low_cnt;
  logic [31:0]        high_cnt;

  logic [63:0] pending_pts[$];
  point_res_t  expected_res[$];
  int  send_idle;
  int  recv_idle;
  int  results_seen;
  int  long_stall_left;
  bit  long_stall_done;
  int  errors;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // log2(1 + i/DEPTH) in Q.30 by repeated squaring, truncated
  function automatic void build_log2_tbl();
    longint unsigned m;
    longint unsigned y;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      m = (64'd1 << 30) + ((longint'(i) << 30) / TBL_DEPTH);
      y = 0;
      for (int k = 1; k <= 30; k++) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          y = y | (64'd1 << (30 - k));
        end
      end
      log2_tbl[i] = y;
    end
    log2_tbl[TBL_DEPTH] = 64'd1 << 30;
  endfunction

  function automatic longint trunc_shift(longint v, int s);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = mag >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // log2(p / 2^30) in Q.30 with interpolation between table entries
  function automatic longint log2_fix(longint unsigned p);
    int b;
    longint unsigned f, sc, idx, rem, lo, hi, fr;
    b = 0;
    while (b < 29 && (p >> (b + 1)) != 0) b++;
    f   = (p << (30 - b)) - (64'd1 << 30);
    sc  = f * TBL_DEPTH;
    idx = sc >> 30;
    if (idx >= TBL_DEPTH) idx = TBL_DEPTH - 1;
    rem = sc - (idx << 30);
    lo  = log2_tbl[idx];
    hi  = log2_tbl[idx + 1];
    fr  = lo + (((hi - lo) * rem) >> 30);
    return (longint'(b) - 30) * Q30 + longint'(fr);
  endfunction

  // Mirror, clamp and update one point; advances the mirror counters
  function automatic point_res_t chempot_update(logic [63:0] pt);
    point_res_t r;
    longint phi, mu, lnr, chit, sum, delta, res;
    longint unsigned mag, dmag;
    phi = longint'($signed(pt[31:0]));
    mu  = longint'($signed(pt[63:32]));
    r.was_low  = 1'b0;
    r.was_high = 1'b0;
    if (phi <= 0) begin
      phi = -phi;
      r.was_low = 1'b1;
      low_cnt = low_cnt + 1;
    end else if (phi >= Q30) begin
      phi = 2 * Q30 - phi;
      r.was_high = 1'b1;
      high_cnt = high_cnt + 1;
    end
    if (phi < 1) phi = 1;
    if (phi > Q30 - 1) phi = Q30 - 1;
    lnr  = trunc_shift((log2_fix(phi) - log2_fix(Q30 - phi)) * LN2, 28);
    chit = trunc_shift(longint'(chi_reg) * (Q30 - 2 * phi), 24);
    sum  = lnr + chit;
    mag  = (sum < 0) ? -sum : sum;
    dmag = (mag * scale_reg[31:16] + ((mag * scale_reg[15:0]) >> 16)) >> 22;
    delta = (sum < 0) ? -longint'(dmag) : longint'(dmag);
    res = mu + delta;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.phi = phi[29:0];
    r.mu  = res[31:0];
    r.low_count  = low_cnt;
    r.high_count = high_cnt;
    return r;
  endfunction

  // Driver: hold the offered point until accepted, then offer the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_res.push_back(chempot_update(s_tdata));
      if (!(s_tvalid && !s_tready)) begin
        if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_tdata  <= pending_pts.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and drive the output stall
  always @(posedge clk) begin
    point_res_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $error("unexpected result transaction, tdata %h", m_tdata);
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (m_tdata[29:0] !== exp_r.phi) begin
            $error("phi_out expected %h actual %h", exp_r.phi, m_tdata[29:0]);
            errors++;
          end
          if (m_tdata[61:30] !== exp_r.mu) begin
            $error("mu_out expected %h actual %h", exp_r.mu, m_tdata[61:30]);
            errors++;
          end
          if (m_tdata[93:62] !== exp_r.low_count) begin
            $error("low_count expected %h actual %h", exp_r.low_count, m_tdata[93:62]);
            errors++;
          end
          if (m_tdata[125:94] !== exp_r.high_count) begin
            $error("high_count expected %h actual %h", exp_r.high_count, m_tdata[125:94]);
            errors++;
          end
          if (m_tuser[0] !== exp_r.was_low) begin
            $error("was_low expected %b actual %b", exp_r.was_low, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== exp_r.was_high) begin
            $error("was_high expected %b actual %b", exp_r.was_high, m_tuser[1]);
            errors++;
          end
        end
      end
      if (!long_stall_done && results_seen >= 500) begin
        long_stall_done = 1'b1;
        long_stall_left = 300;
      end
      if (long_stall_left > 0) begin
        long_stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Write one register and mirror it into the predictor
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == fhcu_pkg::CFG_SCALE) scale_reg = val;
    else if (idx == fhcu_pkg::CFG_CHI) chi_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every queued point has been checked, then let the pipe drain
  task automatic drain_all();
    while (pending_pts.size() > 0 || expected_res.size() > 0 || s_tvalid) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_phi();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h3FFF_FFFF, 1);
      2: return 32'h4000_0000 + $urandom_range(64) - 32;
      3: return $urandom_range(64) - 32;
      4: return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
      default: return -$urandom_range(32'h4000_0000, 0);
    endcase
  endfunction

  initial begin
    logic [31:0] dir_phi[12];
    logic [31:0] dir_mu[3];
    logic [31:0] scale_set[N_PHASES];
    logic [31:0] chi_set[N_PHASES];
    build_log2_tbl();
    scale_reg = fhcu_pkg::SCALE_RESET;
    chi_reg   = fhcu_pkg::CHI_RESET;
    low_cnt   = '0;
    high_cnt  = '0;
    send_idle = 26;
    recv_idle = 47;
    results_seen    = 0;
    long_stall_left = 0;
    long_stall_done = 1'b0;
    errors    = 0;
    cfg_we    = 1'b0;
    cfg_addr  = fhcu_pkg::CFG_SCALE;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed points at reset settings: zero, most negative, exactly one,
    // low mirror landing at one, clamps and saturation of mu
    dir_phi = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                32'h7FFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF, 32'h0000_0001,
                32'h4000_0001, 32'hC000_0000, 32'h2000_0000, 32'hBFFF_FFFF};
    dir_mu  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
    for (int i = 0; i < 12; i++) pending_pts.push_back({dir_mu[i % 3], dir_phi[i]});
    drain_all();

    // Large scale to push mu into saturation both ways, unmapped index ignored
    write_reg(fhcu_pkg::CFG_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, 32'h0000_0000);
    for (int i = 0; i < 8; i++) pending_pts.push_back({dir_mu[i % 2], dir_phi[i]});
    drain_all();

    scale_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0080_0000,
                  32'h2000_0000, 32'h0000_0001, 32'h0400_0000, 32'h00C0_0000};
    chi_set   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFF00_0000,
                  32'h0200_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0180_0000};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 3) begin
        send_idle = 47;
        recv_idle = 26;
      end else if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(fhcu_pkg::CFG_SCALE, scale_set[ph]);
      write_reg(fhcu_pkg::CFG_CHI, chi_set[ph]);
      for (int i = 0; i < PHASE_PTS; i++)
        pending_pts.push_back({32'($urandom), rand_phi()});
      drain_all();
    end

    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("flory_huggins_chempot_update regression: pass");
    end else begin
      $display("flory_huggins_chempot_update regression: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2ms;
    $display("flory_huggins_chempot_update regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
